// ----- hdl/gbnl_pkg.sv -----
// shared types and constants for the grid nearest-label search block
`timescale 1ns / 1ps
package gbnl_pkg;

  // fixed field widths
  localparam int LABEL_W = 8;
  localparam int ROW_W   = 4;
  localparam int COL_W   = 6;
  localparam int DIST_W  = 10;
  localparam int ROWS_W  = 5;
  localparam int COLS_W  = 7;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register indexes, taken from paddr bit 2
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // label of a blocked cell
  localparam logic [LABEL_W-1:0] LABEL_BLOCKED = 8'hFF;

  // per-cell bits shifted down the chain during a load
  typedef struct packed {
    logic open;
    logic target;
    logic src;
  } scan_bits_t;

  // control from the sequencer to every row cell
  typedef struct packed {
    logic load;
    logic step;
  } cell_ctrl_t;

  // status from one row cell
  typedef struct packed {
    logic alive;
    logic hit;
  } cell_stat_t;

endpackage

// ----- hdl/gbnl_cell.sv -----
// one grid row of the search wavefront: open, target, frontier and visited bits
`timescale 1ns / 1ps
module gbnl_cell
  import gbnl_pkg::*;
#(
  parameter int COLS = 64
) (
  input  logic             clk,
  input  cell_ctrl_t       ctrl,
  input  scan_bits_t       scan_in,
  output scan_bits_t       scan_out,
  input  logic [COLS-1:0]  front_up,
  input  logic [COLS-1:0]  front_dn,
  output logic [COLS-1:0]  front,
  output cell_stat_t       stat
);

  logic [COLS-1:0] open_r;
  logic [COLS-1:0] tgt_r;
  logic [COLS-1:0] front_r;
  logic [COLS-1:0] seen_r;
  logic [COLS-1:0] front_nxt;

  // next wavefront: four-neighbour spread into open, unvisited cells
  assign front_nxt = ((front_r << 1) | (front_r >> 1) | front_up | front_dn)
                     & open_r & ~seen_r;

  // serial load from the chain, then one level per step
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      open_r  <= COLS'({scan_in.open, open_r} >> 1);
      tgt_r   <= COLS'({scan_in.target, tgt_r} >> 1);
      front_r <= COLS'({scan_in.src, front_r} >> 1);
      seen_r  <= COLS'({scan_in.src, seen_r} >> 1);
    end else if (ctrl.step) begin
      front_r <= front_nxt;
      seen_r  <= seen_r | front_nxt;
    end
  end

  // bits leaving toward the previous row
  assign scan_out.open   = open_r[0];
  assign scan_out.target = tgt_r[0];
  assign scan_out.src    = front_r[0];

  assign front      = front_r;
  assign stat.alive = |front_r;
  assign stat.hit   = |(front_r & tgt_r);

endmodule

// ----- hdl/grid_bfs_nearest_label.sv -----
// Query steps: accept in idle, scan the labels into the row chain, flush, then search
// (one wavefront level per cycle) until a hit or no frontier, then the output register.
// A write goes straight into the label memory. One query is worked on at a time, its
// length set by the one-read-per-cycle label scan into the row chain and the search.
// A source outside the grid in use skips the scan and search and answers directly.
// Reset (synchronous, active low) clears control and sets rows/cols; labels are kept.
`timescale 1ns / 1ps
module grid_bfs_nearest_label
  import gbnl_pkg::*;
#(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic [ROW_W-1:0]    in_row,
  input  logic [COL_W-1:0]    in_col,
  input  logic signed [LABEL_W-1:0] in_label,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DIST_W-1:0]   out_distance,
  output logic                out_reachable,
  // configuration port
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [APB_AW-1:0]   cfg_paddr,
  input  logic [APB_DW-1:0]   cfg_pwdata,
  output logic [APB_DW-1:0]   cfg_prdata,
  output logic                cfg_pready
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int LW    = AW + 1;
  localparam logic [ROWS_W-1:0] ROWS_RST = ROWS_W'((MAX_ROWS < 16) ? MAX_ROWS : 16);
  localparam logic [COLS_W-1:0] COLS_RST = COLS_W'((MAX_COLS < 64) ? MAX_COLS : 64);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_FLUSH,
    S_RUN,
    S_RESP
  } state_t;

  state_t state_r;

  // configuration registers
  logic [ROWS_W-1:0] rows_r;
  logic [COLS_W-1:0] cols_r;
  logic [ROWS_W-1:0] rows_wr;
  logic [COLS_W-1:0] cols_wr;
  logic              cfg_wr;

  // query context
  logic [ROW_W-1:0]   src_row_r;
  logic [COL_W-1:0]   src_col_r;
  logic [LABEL_W-1:0] tgt_r;
  logic [LW-1:0]      lvl_r;
  logic [DIST_W-1:0]  res_dist_r;
  logic               res_reach_r;
  logic               out_valid_r;
  logic [DIST_W-1:0]  out_distance_r;
  logic               out_reachable_r;

  // scan counters and read pipeline
  logic [AW-1:0]      scan_addr_r;
  logic [RW-1:0]      scan_row_r;
  logic [CW-1:0]      scan_col_r;
  logic               ld_vld_r;
  logic [RW-1:0]      ld_row_r;
  logic [CW-1:0]      ld_col_r;
  logic [LABEL_W-1:0] rd_label_r;

  // label memory
  logic [LABEL_W-1:0] label_mem [CELLS];
  logic               in_acc;
  logic               mem_we;
  logic [AW-1:0]      wr_addr;
  logic               src_in_use;

  // row chain wiring
  scan_bits_t              scan_w  [MAX_ROWS+1];
  logic [MAX_COLS-1:0]     front_w [MAX_ROWS+2];
  cell_stat_t              stat_w  [MAX_ROWS];
  logic [MAX_ROWS-1:0]     hit_vec;
  logic [MAX_ROWS-1:0]     alive_vec;
  logic                    any_hit;
  logic                    any_alive;
  cell_ctrl_t              ctrl;
  logic                    scan_last;
  logic                    col_last;

  // configuration writes, out-of-range values clamped
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    if (cfg_pwdata[ROWS_W-1:0] == '0) begin
      rows_wr = ROWS_W'(1);
    end else if (int'(cfg_pwdata[ROWS_W-1:0]) > MAX_ROWS) begin
      rows_wr = ROWS_W'(MAX_ROWS);
    end else begin
      rows_wr = cfg_pwdata[ROWS_W-1:0];
    end
    if (cfg_pwdata[COLS_W-1:0] == '0) begin
      cols_wr = COLS_W'(1);
    end else if (int'(cfg_pwdata[COLS_W-1:0]) > MAX_COLS) begin
      cols_wr = COLS_W'(MAX_COLS);
    end else begin
      cols_wr = cfg_pwdata[COLS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RST;
      cols_r <= COLS_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_ROWS: rows_r <= rows_wr;
        REG_COLS: cols_r <= cols_wr;
        default:  rows_r <= rows_r;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_paddr[2])
      REG_ROWS: cfg_prdata = APB_DW'(rows_r);
      REG_COLS: cfg_prdata = APB_DW'(cols_r);
      default:  cfg_prdata = '0;
    endcase
  end

  // request decode
  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign mem_we     = in_acc && (in_operation == OP_WRITE)
                      && (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_COLS);
  assign wr_addr    = AW'(int'(in_row) * MAX_COLS + int'(in_col));
  assign src_in_use = (in_row < rows_r) && (in_col < cols_r);

  // label store, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      label_mem[wr_addr] <= in_label;
    end
    rd_label_r <= label_mem[scan_addr_r];
  end

  // bits entering the tail of the chain
  assign scan_w[MAX_ROWS].open   = (rd_label_r != LABEL_BLOCKED)
                                   && (ld_row_r < rows_r) && (ld_col_r < cols_r);
  assign scan_w[MAX_ROWS].target = (rd_label_r == tgt_r);
  assign scan_w[MAX_ROWS].src    = (ld_row_r == src_row_r) && (ld_col_r == src_col_r);

  assign front_w[0]          = '0;
  assign front_w[MAX_ROWS+1] = '0;

  // one cell per grid row
  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_row
    gbnl_cell #(
      .COLS(MAX_COLS)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .scan_in  (scan_w[g+1]),
      .scan_out (scan_w[g]),
      .front_up (front_w[g]),
      .front_dn (front_w[g+2]),
      .front    (front_w[g+1]),
      .stat     (stat_w[g])
    );
    assign hit_vec[g]   = stat_w[g].hit;
    assign alive_vec[g] = stat_w[g].alive;
  end

  assign any_hit   = |hit_vec;
  assign any_alive = |alive_vec;

  // cell control
  assign ctrl.load = ld_vld_r;
  assign ctrl.step = (state_r == S_RUN) && !any_hit && any_alive;

  assign scan_last = (scan_addr_r == AW'(CELLS - 1));
  assign col_last  = (scan_col_r == CW'(MAX_COLS - 1));

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ld_vld_r    <= 1'b0;
    end else begin
      ld_vld_r <= (state_r == S_LOAD);
      ld_row_r <= scan_row_r;
      ld_col_r <= scan_col_r;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && (in_operation == OP_QUERY)) begin
            src_row_r   <= in_row;
            src_col_r   <= in_col;
            tgt_r       <= in_label;
            scan_addr_r <= '0;
            scan_row_r  <= '0;
            scan_col_r  <= '0;
            lvl_r       <= '0;
            if (src_in_use) begin
              state_r <= S_LOAD;
            end else begin
              res_dist_r  <= '0;
              res_reach_r <= 1'b0;
              state_r     <= S_RESP;
            end
          end
        end
        S_LOAD: begin
          scan_addr_r <= scan_addr_r + AW'(1);
          if (col_last) begin
            scan_col_r <= '0;
            scan_row_r <= scan_row_r + RW'(1);
          end else begin
            scan_col_r <= scan_col_r + CW'(1);
          end
          if (scan_last) begin
            state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          state_r <= S_RUN;
        end
        S_RUN: begin
          if (any_hit) begin
            res_dist_r  <= DIST_W'(lvl_r);
            res_reach_r <= 1'b1;
            state_r     <= S_RESP;
          end else if (!any_alive) begin
            res_dist_r  <= '0;
            res_reach_r <= 1'b0;
            state_r     <= S_RESP;
          end else begin
            lvl_r <= lvl_r + LW'(1);
          end
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r     <= 1'b1;
            out_distance_r  <= res_dist_r;
            out_reachable_r <= res_reach_r;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_distance  = out_distance_r;
  assign out_reachable = out_reachable_r;

`ifndef SYNTHESIS
  // an unreachable answer always carries distance zero
  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reachable |-> out_distance == '0)
    else $error("unreachable result with nonzero distance");

  // the search never runs more levels than there are cells
  a_lvl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> int'(lvl_r) < CELLS)
    else $error("search level beyond grid size");

  // the scan only leaves through the flush cycle
  a_load_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOAD |=> state_r == S_LOAD || state_r == S_FLUSH)
    else $error("scan left without flush");

  // a new result comes only out of the response state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_RESP))
    else $error("result appeared outside response state");
`endif

endmodule
